// File: rtl/core/icc_pkg.sv
// Types and constants for the image CRC-32 integrity checker.
// No dependencies; imported by icc_step and image_crc32_integrity_check.
`default_nettype none

package icc_pkg;

  localparam logic [31:0] CRC_PRESET    = 32'hFFFF_FFFF;
  localparam logic [3:0]  NIB_MASK      = 4'hF;
  localparam logic [2:0]  TRAILER_BYTES = 3'd4;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] data_byte;
    logic       in_trailer;
  } icc_in_t;

  typedef struct packed {
    logic [31:0] crc_so_far;
    logic        check_done;
    logic        image_ok;
  } icc_out_t;

  typedef struct packed {
    logic [31:0] crc;
    logic [31:0] stored_crc;
    logic [2:0]  trailer_count;
  } icc_state_t;

  // Reflected CRC-32 nibble table, polynomial 0xEDB88320
  function automatic logic [31:0] nibble_table(input logic [3:0] idx);
    logic [31:0] val;
    case (idx)
      4'h0:    val = 32'h0000_0000;
      4'h1:    val = 32'h1DB7_1064;
      4'h2:    val = 32'h3B6E_20C8;
      4'h3:    val = 32'h26D9_30AC;
      4'h4:    val = 32'h76DC_4190;
      4'h5:    val = 32'h6B6B_51F4;
      4'h6:    val = 32'h4DB2_6158;
      4'h7:    val = 32'h5005_713C;
      4'h8:    val = 32'hEDB8_8320;
      4'h9:    val = 32'hF00F_9344;
      4'hA:    val = 32'hD6D6_A3E8;
      4'hB:    val = 32'hCB61_B38C;
      4'hC:    val = 32'h9B64_C2B0;
      4'hD:    val = 32'h86D3_D2D4;
      4'hE:    val = 32'hA00A_E278;
      4'hF:    val = 32'hBDBD_F21C;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] nibble_step(input logic [31:0] crc, input logic [3:0] nib);
    logic [3:0] idx;
    idx = (crc[3:0] ^ nib) & NIB_MASK;
    return nibble_table(idx) ^ (crc >> 4);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/icc_step.sv
// Per-byte update: CRC over image bytes, trailer gathering and the final compare.
// Depends on icc_pkg.
`default_nettype none

module icc_step
  import icc_pkg::*;
(
  input  wire icc_in_t    req,
  input  wire icc_state_t state_cur,
  output icc_state_t      state_nxt,
  output icc_out_t        result
);

  icc_state_t base;
  logic       done;

  always_comb begin
    base = state_cur;
    if (req.start_of_image) begin
      base.crc           = CRC_PRESET;
      base.stored_crc    = '0;
      base.trailer_count = '0;
    end

    state_nxt = base;
    done      = 1'b0;
    if (!req.in_trailer) begin
      state_nxt.crc = nibble_step(nibble_step(base.crc, req.data_byte[3:0]),
                                  req.data_byte[7:4]);
    end else if (base.trailer_count < TRAILER_BYTES) begin
      // little-endian: byte n lands in bits 8n+7..8n
      state_nxt.stored_crc[{base.trailer_count[1:0], 3'b000} +: 8] = req.data_byte;
      state_nxt.trailer_count = base.trailer_count + 3'd1;
      done = (state_nxt.trailer_count == TRAILER_BYTES);
    end

    result.crc_so_far = ~state_nxt.crc;
    result.check_done = done;
    result.image_ok   = done && (state_nxt.stored_crc == ~state_nxt.crc);
  end

endmodule

`default_nettype wire

// File: rtl/core/image_crc32_integrity_check.sv
// Top level of the firmware image CRC-32 checker: input register, state and result register.
// Depends on icc_pkg and icc_step.
`default_nettype none

// Streams a firmware image one byte per request and keeps a reflected CRC-32
// (preset all ones). Image bytes (in_trailer low) update the CRC; trailer bytes
// are gathered little-endian into a stored CRC, and the fourth one raises
// check_done with image_ok set when it equals the inverted running CRC.
// start_of_image re-presets the CRC and clears the trailer before its byte.
// Every request gives exactly one result, which passes the input register and then the
// result register; a new request is taken every cycle while out_ready does not stall the
// output: the byte update is combinational table logic between the two registers.
module image_crc32_integrity_check
  import icc_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  input  wire      icc_in_t in_data,
  output logic     out_valid,
  input  wire      out_ready,
  output icc_out_t out_data
);

  icc_in_t    req_r;
  logic       req_valid_r;
  icc_state_t state_r;
  icc_state_t state_nxt;
  icc_out_t   result_nxt;
  icc_out_t   out_r;
  logic       out_valid_r;
  logic       advance;

  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  icc_step u_step (
    .req       (req_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r           <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.crc           <= CRC_PRESET;
      state_r.stored_crc    <= '0;
      state_r.trailer_count <= '0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
    if (advance) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for image_crc32_integrity_check: directed rows, then random images.
// Depends on icc_pkg and the RTL; expected results: a bitwise CRC model or typed-in rows.

module tb_top
  import icc_pkg::*;
();

  localparam int          N_ITEMS    = 1650;
  localparam int          IDLE_PCT   = 29;
  localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CHECK_123  = 32'hCBF4_3926;  // CRC-32 of "123456789"

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  icc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  icc_out_t out_data;

  // directed stimulus, with a typed-in result where one is obvious
  typedef struct {
    icc_in_t  req;
    bit       has_exp;
    icc_out_t exp;
  } dir_row_t;

  dir_row_t    dir_rows[$];
  icc_out_t    expected_results[$];
  logic [31:0] model_crc;
  logic [31:0] model_stored;
  logic [2:0]  model_count;
  int          sent     = 0;
  int          mismatch = 0;
  bit          calm     = 1'b0;

  image_crc32_integrity_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // bit-serial reflected CRC, independent of the nibble table in the RTL
  function automatic icc_out_t image_check_predict(input icc_in_t req);
    icc_out_t res;
    logic     done;
    done = 1'b0;
    if (req.start_of_image) begin
      model_crc    = CRC_PRESET;
      model_stored = '0;
      model_count  = '0;
    end
    if (!req.in_trailer) begin
      model_crc = model_crc ^ {24'h0, req.data_byte};
      for (int b = 0; b < 8; b++)
        model_crc = (model_crc >> 1) ^ (model_crc[0] ? CRC32_POLY : 32'h0);
    end else if (model_count < TRAILER_BYTES) begin
      model_stored = model_stored | ({24'h0, req.data_byte} << (8 * model_count));
      model_count  = model_count + 3'd1;
      done         = (model_count == TRAILER_BYTES);
    end
    res.crc_so_far = ~model_crc;
    res.check_done = done;
    res.image_ok   = done && (model_stored == ~model_crc);
    return res;
  endfunction

  task automatic add_row(input logic sof, input logic [7:0] b, input logic trl,
                         input bit has_exp = 1'b0, input logic [31:0] crc = '0,
                         input logic done = 1'b0, input logic ok = 1'b0);
    dir_row_t row;
    row.req.start_of_image = sof;
    row.req.data_byte      = b;
    row.req.in_trailer     = trl;
    row.has_exp            = has_exp;
    row.exp.crc_so_far     = crc;
    row.exp.check_done     = done;
    row.exp.image_ok       = ok;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic sof, input logic [7:0] b, input logic trl,
                          input bit has_exp = 1'b0, input icc_out_t typed = '0);
    icc_in_t  req;
    icc_out_t pred;
    req.start_of_image = sof;
    req.data_byte      = b;
    req.in_trailer     = trl;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = image_check_predict(req);
    expected_results.push_back(has_exp ? typed : pred);
    sent++;
    @(negedge clk);
  endtask

  // one image: body bytes, then a trailer that is usually right
  task automatic send_image();
    int          n_img;
    int          n_trl;
    int          mode;
    logic [31:0] trl_val;
    n_img = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(12);
    for (int i = 0; i < n_img; i++)
      send_req(i == 0, 8'($urandom_range(255)), 1'b0);
    mode    = $urandom_range(9);
    trl_val = ~model_crc;
    n_trl   = 4;
    if (mode inside {[6:7]})
      trl_val = trl_val ^ (32'h1 << $urandom_range(31));
    else if (mode == 8)
      n_trl = $urandom_range(1, 3);
    else if (mode == 9)
      trl_val = $urandom;
    for (int k = 0; k < n_trl; k++)
      send_req(n_img == 0 && k == 0, trl_val[8*k +: 8], 1'b1);
    // surplus trailer bytes, or image bytes after the trailer
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_req(1'b0, 8'($urandom_range(255)), 1'b1);
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 3)) send_req(1'b0, 8'($urandom_range(255)), 1'b0);
  endtask

  always @(negedge clk)
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    icc_out_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatch < 10)
          $display("unexpected result: crc %h done %b ok %b",
                   out_data.crc_so_far, out_data.check_done, out_data.image_ok);
        mismatch++;
      end else begin
        exp = expected_results.pop_front();
        if (out_data.crc_so_far !== exp.crc_so_far ||
            out_data.check_done !== exp.check_done ||
            out_data.image_ok   !== exp.image_ok) begin
          if (mismatch < 10)
            $display("mismatch: crc %h/%h done %b/%b ok %b/%b (exp/act)",
                     exp.crc_so_far, out_data.crc_so_far, exp.check_done,
                     out_data.check_done, exp.image_ok, out_data.image_ok);
          mismatch++;
        end
      end
    end
  end

  initial begin
    model_crc    = CRC_PRESET;
    model_stored = '0;
    model_count  = '0;

    // trailer straight after reset, then start landing on a trailer byte
    add_row(1'b0, 8'hAB, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0);
    add_row(1'b1, 8'h00, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0);
    add_row(1'b0, 8'h00, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0);
    add_row(1'b0, 8'h00, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0);
    add_row(1'b0, 8'h00, 1'b1, 1'b1, 32'h0, 1'b1, 1'b1);
    add_row(1'b0, 8'hFF, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0);  // surplus trailer byte
    add_row(1'b0, 8'hFF, 1'b0);                           // image byte after trailer
    // standard check string, then its own CRC as trailer
    for (int i = 0; i < 9; i++)
      add_row(i == 0, 8'h31 + i[7:0], 1'b0, i == 8, CHECK_123);
    add_row(1'b0, 8'h26, 1'b1, 1'b1, CHECK_123, 1'b0, 1'b0);
    add_row(1'b0, 8'h39, 1'b1, 1'b1, CHECK_123, 1'b0, 1'b0);
    add_row(1'b0, 8'hF4, 1'b1, 1'b1, CHECK_123, 1'b0, 1'b0);
    add_row(1'b0, 8'hCB, 1'b1, 1'b1, CHECK_123, 1'b1, 1'b1);
    add_row(1'b0, 8'h00, 1'b0);
    // wrong trailer
    add_row(1'b1, 8'hFF, 1'b0);
    add_row(1'b0, 8'h00, 1'b1);
    add_row(1'b0, 8'hFF, 1'b1);
    add_row(1'b0, 8'h80, 1'b1);
    add_row(1'b0, 8'h01, 1'b1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_req(dir_rows[i].req.start_of_image, dir_rows[i].req.data_byte,
               dir_rows[i].req.in_trailer, dir_rows[i].has_exp, dir_rows[i].exp);

    while (sent < N_ITEMS + dir_rows.size()) begin
      calm = (sent >= 700 && sent < 1000);
      if ($urandom_range(99) < 15) begin
        // loose requests, starts included
        repeat ($urandom_range(1, 5))
          send_req($urandom_range(7) == 0, 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end else begin
        send_image();
      end
    end
    calm     = 1'b0;
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
